[hdl/ucfp_pkg.sv]
// ucfp_pkg: shared constants, types and tables of the uart command frame parser
// character codes, keyword table, fixed-point widths and the fraction scaling table
// no dependencies
`timescale 1ns / 1ps

package ucfp_pkg;

   localparam int MAX_FRAME   = 32;
   localparam int FRAC_BITS   = 24;
   localparam int FRAC_DIGITS = 5;

   localparam int BYTE_W  = 8;
   localparam int CMD_W   = 5;
   localparam int VALUE_W = 56;
   localparam int POS_W   = 6;
   localparam int NAME_W  = 32;
   localparam int INT_W   = 40;

   localparam logic [BYTE_W-1:0] CH_BANG    = 8'h21;
   localparam logic [BYTE_W-1:0] CH_EQ      = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_POINT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_P       = 8'h50;
   localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_NONE = 5'd0;
   localparam logic [CMD_W-1:0] CMD_STOP = 5'd19;
   localparam logic [CMD_W-1:0] CMD_BUZ  = 5'd20;

   localparam int NUM_KEYS = 20;
   localparam int STOP_KEY = 18;

   typedef logic [3*BYTE_W-1:0] key_tab_type [NUM_KEYS];

   // first character in the top byte
   localparam key_tab_type KEY_TAB = '{
      "Skp", "Ski", "Skd", "Ckp", "Cki", "Ckd", "BRU", "MOT", "FAN", "LMO",
      "RMO", "LFA", "RFA", "FON", "SPE", "ENP", "ENI", "END", "STO", "Buz"
   };

   function automatic longint unsigned pow10(input int n);
      longint unsigned p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

   localparam longint unsigned DEN = pow10(FRAC_DIGITS);

   // fraction magnitude, also after scaling to FRAC_DIGITS places
   localparam int MAG_W    = $clog2(23 * DEN);
   localparam int FACC_W   = MAG_W + 1;
   localparam int PLACES_W = $clog2(FRAC_DIGITS + 1);
   localparam int SCALE_W  = $clog2(DEN + 1);

   // reciprocal of DEN, one correction step afterwards
   localparam longint unsigned RECIP = (64'd1 << (FRAC_BITS + MAG_W)) / DEN;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int Q_W     = RECIP_W;
   localparam int REM_W   = $clog2(DEN) + 2;

   localparam int IP_W  = VALUE_W - FRAC_BITS + 2;
   localparam int SUM_W = VALUE_W + 2;
   localparam longint IP_LIM = longint'(1) << (VALUE_W - FRAC_BITS);

   localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef logic [SCALE_W-1:0] scale_tab_type [FRAC_DIGITS+1];

   function automatic scale_tab_type make_scale_tab();
      scale_tab_type t;
      for (int p = 0; p <= FRAC_DIGITS; p++) begin
         t[p] = SCALE_W'(pow10(FRAC_DIGITS - p));
      end
      return t;
   endfunction

   localparam scale_tab_type SCALE_TAB = make_scale_tab();

   function automatic logic [CMD_W-1:0] lookup_command(input logic [NAME_W-1:0] name);
      logic [CMD_W-1:0] cmd;
      logic hit;
      cmd = CMD_NONE;
      for (int c = NUM_KEYS - 1; c >= 0; c--) begin
         hit = (name[7:0] == KEY_TAB[c][23:16]) && (name[15:8] == KEY_TAB[c][15:8])
               && (name[23:16] == KEY_TAB[c][7:0]);
         if (c == STOP_KEY) begin
            hit = hit && (name[31:24] == CH_P);
         end
         if (hit) begin
            cmd = CMD_W'(c + 1);
         end
      end
      return cmd;
   endfunction

   typedef struct packed {
      logic [CMD_W-1:0]       command;
      logic                   stop_state;
      logic                   buzzer_level;
      logic                   overflow;
      logic                   has_value;
      logic                   negative;
      logic signed [IP_W-1:0] ip;
   } ucfp_meta_type;

   typedef struct packed {
      ucfp_meta_type    meta;
      logic             frac_neg;
      logic [MAG_W-1:0] mag;
   } ucfp_close_type;

endpackage

[hdl/uart_command_frame_parser.sv]
// uart_command_frame_parser: top level of the !NAME=value! command frame parser
// instantiates ucfp_frame and ucfp_value; depends on ucfp_pkg
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_rx_byte
//   rsp      out        rsp_valid/rsp_stall   rsp_command, rsp_value, rsp_stop_state,
//                                             rsp_buzzer_level, rsp_overflow
//
// one byte accepted per cycle while req_stall is low; a closing '!' yields a response
// after the reciprocal divide, correction and saturation stages of ucfp_value
// synchronous active-high reset clears frame state and the stop and buzzer flags
// req_stall rises only when all six result stages hold responses under rsp_stall
`timescale 1ns / 1ps

module uart_command_frame_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ucfp_pkg::BYTE_W-1:0]          req_rx_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ucfp_pkg::CMD_W-1:0]           rsp_command,
   output logic signed [ucfp_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                 rsp_stop_state,
   output logic                                 rsp_buzzer_level,
   output logic                                 rsp_overflow
);
   import ucfp_pkg::*;

   logic           accept;
   logic           ready;
   logic           close_valid;
   ucfp_close_type close;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   ucfp_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .close_valid (close_valid),
      .close       (close)
   );

   ucfp_value u_value (
      .clock            (clock),
      .reset            (reset),
      .close_valid      (close_valid),
      .close            (close),
      .ready            (ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_value        (rsp_value),
      .rsp_stop_state   (rsp_stop_state),
      .rsp_buzzer_level (rsp_buzzer_level),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

[hdl/ucfp_frame.sv]
// ucfp_frame: per-byte frame tracking, name capture and decimal accumulation
// emits one close request per closing '!' with command, flags and scaled fraction
// depends on ucfp_pkg
`timescale 1ns / 1ps

module ucfp_frame (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [ucfp_pkg::BYTE_W-1:0]  rx_byte,
   output logic                         close_valid,
   output ucfp_pkg::ucfp_close_type     close
);
   import ucfp_pkg::*;

   logic                       receiving_ff, receiving_in;
   logic [POS_W-1:0]           position_ff, position_in;
   logic [NAME_W-1:0]          name_ff, name_in;
   logic                       in_value_ff, in_value_in;
   logic                       negative_ff, negative_in;
   logic                       after_point_ff, after_point_in;
   logic                       fresh_ff, fresh_in;
   logic                       too_long_ff, too_long_in;
   logic signed [INT_W-1:0]    int_acc_ff, int_acc_in;
   logic signed [FACC_W-1:0]   frac_acc_ff, frac_acc_in;
   logic [PLACES_W-1:0]        places_ff, places_in;
   logic                       stop_ff, stop_in;
   logic                       buzz_ff, buzz_in;

   logic signed [BYTE_W+1:0]   digit;
   logic signed [INT_W+4:0]    int_wide, int_next;
   logic signed [FACC_W+3:0]   frac_wide, frac_next;
   logic [NAME_W-1:0]          name_cur;
   logic                       too_long_new;
   logic [CMD_W-1:0]           cmd;
   logic                       toggle_stop, toggle_buzz;
   longint                     ip_wide, ip_clamped;
   logic [FACC_W-1:0]          frac_abs;
   logic [MAG_W+SCALE_W-1:0]   mag_prod;

   always_comb begin
      digit     = $signed({2'b00, rx_byte}) - $signed({2'b00, DIGIT_BASE});
      int_wide  = (INT_W+5)'(int_acc_ff);
      int_next  = (int_wide <<< 3) + (int_wide <<< 1) + (INT_W+5)'(digit);
      frac_wide = (FACC_W+4)'(frac_acc_ff);
      frac_next = (frac_wide <<< 3) + (frac_wide <<< 1) + (FACC_W+4)'(digit);

      name_cur = name_ff;
      for (int k = 1; k <= 4; k++) begin
         if (position_ff == POS_W'(k)) begin
            name_cur[8*(k-1) +: 8] = rx_byte;
         end
      end

      too_long_new = too_long_ff | (position_ff >= POS_W'(MAX_FRAME));
      cmd          = too_long_new ? CMD_NONE : lookup_command(name_cur);
      toggle_stop  = (cmd == CMD_STOP);
      toggle_buzz  = (cmd == CMD_BUZ);

      ip_wide = longint'(int_acc_ff);
      if (ip_wide > IP_LIM) begin
         ip_clamped = IP_LIM;
      end else if (ip_wide < -IP_LIM) begin
         ip_clamped = -IP_LIM;
      end else begin
         ip_clamped = ip_wide;
      end

      frac_abs = frac_acc_ff[FACC_W-1] ? -frac_acc_ff : frac_acc_ff;
      mag_prod = (MAG_W+SCALE_W)'(frac_abs[MAG_W-1:0])
                 * (MAG_W+SCALE_W)'(SCALE_TAB[places_ff]);

      close.meta.command      = cmd;
      close.meta.stop_state   = stop_ff ^ toggle_stop;
      close.meta.buzzer_level = buzz_ff ^ toggle_buzz;
      close.meta.overflow     = too_long_new;
      close.meta.has_value    = in_value_ff & ~too_long_new;
      close.meta.negative     = negative_ff;
      close.meta.ip           = IP_W'(ip_clamped);
      close.frac_neg          = frac_acc_ff[FACC_W-1];
      close.mag               = mag_prod[MAG_W-1:0];

      receiving_in   = receiving_ff;
      position_in    = position_ff;
      name_in        = name_ff;
      in_value_in    = in_value_ff;
      negative_in    = negative_ff;
      after_point_in = after_point_ff;
      fresh_in       = fresh_ff;
      too_long_in    = too_long_ff;
      int_acc_in     = int_acc_ff;
      frac_acc_in    = frac_acc_ff;
      places_in      = places_ff;
      stop_in        = stop_ff;
      buzz_in        = buzz_ff;
      close_valid    = 1'b0;

      if (accept) begin
         if (!receiving_ff) begin
            if (rx_byte == CH_BANG) begin
               receiving_in = 1'b1;
               position_in  = POS_W'(1);
            end
         end else if (rx_byte != CH_BANG) begin
            position_in = (position_ff != POS_MAX) ? position_ff + 1'b1 : position_ff;
            name_in     = name_cur;
            too_long_in = too_long_new;
            if (rx_byte == CH_EQ) begin
               in_value_in    = 1'b1;
               negative_in    = 1'b0;
               after_point_in = 1'b0;
               int_acc_in     = '0;
               frac_acc_in    = '0;
               places_in      = '0;
               fresh_in       = 1'b1;
            end else if (in_value_ff) begin
               fresh_in = 1'b0;
               if (fresh_ff && rx_byte == CH_MINUS) begin
                  negative_in = 1'b1;
               end else if (rx_byte == CH_POINT && !after_point_ff) begin
                  after_point_in = 1'b1;
               end else if (after_point_ff) begin
                  if (places_ff < PLACES_W'(FRAC_DIGITS)) begin
                     frac_acc_in = frac_next[FACC_W-1:0];
                     places_in   = places_ff + 1'b1;
                  end
               end else if (!(&int_next[INT_W+4:INT_W-1])
                            && (|int_next[INT_W+4:INT_W-1])) begin
                  int_acc_in = int_next[INT_W+4] ? {1'b1, {(INT_W-1){1'b0}}}
                                                 : {1'b0, {(INT_W-1){1'b1}}};
               end else begin
                  int_acc_in = int_next[INT_W-1:0];
               end
            end
         end else begin
            close_valid    = 1'b1;
            stop_in        = stop_ff ^ toggle_stop;
            buzz_in        = buzz_ff ^ toggle_buzz;
            receiving_in   = 1'b0;
            position_in    = '0;
            name_in        = '0;
            in_value_in    = 1'b0;
            negative_in    = 1'b0;
            after_point_in = 1'b0;
            fresh_in       = 1'b0;
            too_long_in    = 1'b0;
            int_acc_in     = '0;
            frac_acc_in    = '0;
            places_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff   <= 1'b0;
         position_ff    <= '0;
         name_ff        <= '0;
         in_value_ff    <= 1'b0;
         negative_ff    <= 1'b0;
         after_point_ff <= 1'b0;
         fresh_ff       <= 1'b0;
         too_long_ff    <= 1'b0;
         int_acc_ff     <= '0;
         frac_acc_ff    <= '0;
         places_ff      <= '0;
         stop_ff        <= 1'b0;
         buzz_ff        <= 1'b0;
      end else begin
         receiving_ff   <= receiving_in;
         position_ff    <= position_in;
         name_ff        <= name_in;
         in_value_ff    <= in_value_in;
         negative_ff    <= negative_in;
         after_point_ff <= after_point_in;
         fresh_ff       <= fresh_in;
         too_long_ff    <= too_long_in;
         int_acc_ff     <= int_acc_in;
         frac_acc_ff    <= frac_acc_in;
         places_ff      <= places_in;
         stop_ff        <= stop_in;
         buzz_ff        <= buzz_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_position: assert property (@(posedge clock) disable iff (reset)
      !receiving_ff |-> position_ff == '0)
      else $error("position nonzero while idle");

   a_stop_on_close: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && (stop_ff != $past(stop_ff)) |-> $past(close_valid))
      else $error("stop flag changed outside a frame close");
`endif

endmodule

[hdl/ucfp_value.sv]
// ucfp_value: fixed-point conversion pipeline and result register
// reciprocal divide of the fraction, correction, integer merge and saturation
// depends on ucfp_pkg
`timescale 1ns / 1ps

module ucfp_value (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 close_valid,
   input  ucfp_pkg::ucfp_close_type             close,
   output logic                                 ready,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ucfp_pkg::CMD_W-1:0]           rsp_command,
   output logic signed [ucfp_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                 rsp_stop_state,
   output logic                                 rsp_buzzer_level,
   output logic                                 rsp_overflow
);
   import ucfp_pkg::*;

   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;

   ucfp_close_type                 c1_ff;
   ucfp_meta_type                  m2_ff, m3_ff, m4_ff, m5_ff;
   logic [MAG_W+RECIP_W-1:0]       prod2_ff, prod2_in;
   logic [MAG_W-1:0]               mag2_ff;
   logic                           neg2_ff, neg3_ff;
   logic [Q_W-1:0]                 q3_ff, q3_in;
   logic [REM_W-1:0]               qd3_ff, qd3_in, ml3_ff, ml3_in;
   logic signed [Q_W+1:0]          q4_ff, q4_in;
   logic signed [VALUE_W-1:0]      s5_ff, s5_in;

   logic [MAG_W+FRAC_BITS-1:0]     mag_shift;
   logic [REM_W-1:0]               rem;
   logic [Q_W:0]                   q_mag;
   logic signed [SUM_W-1:0]        ip_ext, sum;
   logic signed [VALUE_W:0]        neg_val;

   logic [CMD_W-1:0]               command_ff;
   logic signed [VALUE_W-1:0]      value_ff, value_in;
   logic                           stop_state_ff, buzzer_level_ff, overflow_ff;

   assign rdy_out = !rsp_valid_ff || !rsp_stall;
   assign rdy5    = !v5_ff || rdy_out;
   assign rdy4    = !v4_ff || rdy5;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;
   assign ready   = rdy1;

   always_comb begin
      prod2_in = (MAG_W+RECIP_W)'(c1_ff.mag) * (MAG_W+RECIP_W)'(RECIP);

      q3_in     = prod2_ff[MAG_W+RECIP_W-1:MAG_W];
      qd3_in    = REM_W'(REM_W'(q3_in) * REM_W'(DEN));
      mag_shift = {mag2_ff, {FRAC_BITS{1'b0}}};
      ml3_in    = mag_shift[REM_W-1:0];

      rem   = ml3_ff - qd3_ff;
      q_mag = (Q_W+1)'(q3_ff) + (Q_W+1)'(rem >= REM_W'(DEN));
      q4_in = neg3_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

      ip_ext = SUM_W'($signed(m4_ff.ip));
      sum    = (ip_ext <<< FRAC_BITS) + SUM_W'(q4_ff);
      if (!(&sum[SUM_W-1:VALUE_W-1]) && (|sum[SUM_W-1:VALUE_W-1])) begin
         s5_in = sum[SUM_W-1] ? VAL_MIN : VAL_MAX;
      end else begin
         s5_in = sum[VALUE_W-1:0];
      end

      neg_val = -(VALUE_W+1)'(s5_ff);
      if (!m5_ff.has_value) begin
         value_in = '0;
      end else if (!m5_ff.negative) begin
         value_in = s5_ff;
      end else if (neg_val[VALUE_W] != neg_val[VALUE_W-1]) begin
         value_in = VAL_MAX;
      end else begin
         value_in = neg_val[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= close_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy_out) begin
            rsp_valid_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         c1_ff <= close;
      end
      if (rdy2) begin
         m2_ff    <= c1_ff.meta;
         prod2_ff <= prod2_in;
         mag2_ff  <= c1_ff.mag;
         neg2_ff  <= c1_ff.frac_neg;
      end
      if (rdy3) begin
         m3_ff   <= m2_ff;
         q3_ff   <= q3_in;
         qd3_ff  <= qd3_in;
         ml3_ff  <= ml3_in;
         neg3_ff <= neg2_ff;
      end
      if (rdy4) begin
         m4_ff <= m3_ff;
         q4_ff <= q4_in;
      end
      if (rdy5) begin
         m5_ff <= m4_ff;
         s5_ff <= s5_in;
      end
      if (rdy_out) begin
         command_ff      <= m5_ff.command;
         value_ff        <= value_in;
         stop_state_ff   <= m5_ff.stop_state;
         buzzer_level_ff <= m5_ff.buzzer_level;
         overflow_ff     <= m5_ff.overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command      = command_ff;
   assign rsp_value        = value_ff;
   assign rsp_stop_state   = stop_state_ff;
   assign rsp_buzzer_level = buzzer_level_ff;
   assign rsp_overflow     = overflow_ff;

`ifndef NO_ASSERTIONS
   a_overflow_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && overflow_ff |-> command_ff == CMD_NONE && value_ff == '0)
      else $error("overlong frame carries a command or value");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rdy4 |=> v3_ff && $stable(q3_ff))
      else $error("blocked divide stage lost its request");
`endif

endmodule

[tb/uart_command_frame_parser_tb.sv]
// uart_command_frame_parser_tb: self-checking testbench of the !NAME=value! frame parser
// directed byte table, then random frames, checked against a byte-level parser model
// depends on ucfp_pkg and uart_command_frame_parser
`timescale 1ns / 1ps

module uart_command_frame_parser_tb;

   import ucfp_pkg::*;

   localparam int     CYCLE_LIMIT    = 500000;
   localparam int     REQUEST_TARGET = 1000;
   localparam int     DRAIN_CYCLES   = 20;
   localparam longint INT_HI         = (longint'(1) <<< (INT_W - 1)) - 1;
   localparam longint INT_LO         = -(longint'(1) <<< (INT_W - 1));
   localparam longint WHOLE_LIMIT    = longint'(1) <<< (VALUE_W - FRAC_BITS);
   localparam int     LEN_MAX        = 63;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [VALUE_W-1:0] value;
      logic                      stop_state;
      logic                      buzzer_level;
      logic                      overflow;
   } frame_result_type;

   typedef struct {
      logic [BYTE_W-1:0] rx_byte;
      bit                typed;
      frame_result_type  result;
   } directed_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [BYTE_W-1:0]           req_rx_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [CMD_W-1:0]            rsp_command;
   logic signed [VALUE_W-1:0]   rsp_value;
   logic                        rsp_stop_state;
   logic                        rsp_buzzer_level;
   logic                        rsp_overflow;

   // parser model state
   bit          in_frame, have_value, minus_seen, in_fraction, stop_bit, buzzer_bit;
   bit          over_length, just_equals;
   int          frame_len, fraction_places;
   logic [31:0] name_word;
   longint      whole_acc, fraction_acc;

   string key_names [NUM_KEYS] = '{
      "Skp", "Ski", "Skd", "Ckp", "Cki", "Ckd", "BRU", "MOT", "FAN", "LMO",
      "RMO", "LFA", "RFA", "FON", "SPE", "ENP", "ENI", "END", "STOP", "Buz"
   };

   frame_result_type  results_due [$];
   frame_result_type  oldest;
   logic [BYTE_W-1:0] frame_q [$];
   directed_row_type  directed_rows [24];

   int error_count = 0;
   int request_count = 0;
   int frame_count = 0;
   int long_frames = 0;
   int toggle_count = 0;
   int saturated_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   uart_command_frame_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .rsp_value        (rsp_value),
      .rsp_stop_state   (rsp_stop_state),
      .rsp_buzzer_level (rsp_buzzer_level),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void start_idle();
      in_frame        = 1'b0;
      frame_len       = 0;
      name_word       = '0;
      have_value      = 1'b0;
      minus_seen      = 1'b0;
      in_fraction     = 1'b0;
      whole_acc       = 0;
      fraction_acc    = 0;
      fraction_places = 0;
      over_length     = 1'b0;
      just_equals     = 1'b0;
   endfunction

   function automatic longint clamp_to_value(input longint v);
      if (v > longint'(VAL_MAX)) return longint'(VAL_MAX);
      if (v < longint'(VAL_MIN)) return longint'(VAL_MIN);
      return v;
   endfunction

   // advances the model by one byte, returns 1 when the byte closes a frame
   function automatic bit parse_uart_byte(input logic [BYTE_W-1:0] b,
                                          output frame_result_type res);
      int     idx, c, k;
      bit     hit;
      longint d, acc, whole, mag, q, total, scale;
      res = '0;
      if (!in_frame) begin
         if (b == CH_BANG) begin
            start_idle();
            in_frame  = 1'b1;
            frame_len = 1;
         end
         return 1'b0;
      end
      idx = frame_len;
      if (frame_len >= MAX_FRAME) over_length = 1'b1;
      if (frame_len < LEN_MAX) frame_len++;
      if (idx >= 1 && idx <= 4) name_word[8*(idx-1) +: 8] = b;

      if (b != CH_BANG) begin
         d = longint'(b) - longint'(DIGIT_BASE);
         if (b == CH_EQ) begin
            have_value      = 1'b1;
            minus_seen      = 1'b0;
            in_fraction     = 1'b0;
            whole_acc       = 0;
            fraction_acc    = 0;
            fraction_places = 0;
            just_equals     = 1'b1;
         end else if (have_value) begin
            if (just_equals && b == CH_MINUS) begin
               minus_seen  = 1'b1;
               just_equals = 1'b0;
            end else begin
               just_equals = 1'b0;
               if (b == CH_POINT && !in_fraction) begin
                  in_fraction = 1'b1;
               end else if (in_fraction) begin
                  if (fraction_places < FRAC_DIGITS) begin
                     fraction_acc = fraction_acc * 10 + d;
                     fraction_places++;
                  end
               end else begin
                  acc = whole_acc * 10 + d;
                  if (acc > INT_HI) acc = INT_HI;
                  if (acc < INT_LO) acc = INT_LO;
                  whole_acc = acc;
               end
            end
         end
         return 1'b0;
      end

      if (!over_length) begin
         res.command = CMD_NONE;
         for (c = 0; c < NUM_KEYS; c++) begin
            if (res.command == CMD_NONE) begin
               hit = 1'b1;
               for (k = 0; k < key_names[c].len(); k++) begin
                  if (name_word[8*k +: 8] != key_names[c][k]) hit = 1'b0;
               end
               if (hit) res.command = CMD_W'(c + 1);
            end
         end
         if (have_value) begin
            whole = whole_acc;
            if (whole > WHOLE_LIMIT) whole = WHOLE_LIMIT;
            if (whole < -WHOLE_LIMIT) whole = -WHOLE_LIMIT;
            mag = (fraction_acc < 0) ? -fraction_acc : fraction_acc;
            scale = 1;
            repeat (fraction_places) scale = scale * 10;
            q = (mag <<< FRAC_BITS) / scale;
            if (fraction_acc < 0) q = -q;
            total = clamp_to_value(whole * (longint'(1) <<< FRAC_BITS) + q);
            if (minus_seen) total = clamp_to_value(-total);
            res.value = total[VALUE_W-1:0];
         end
         if (res.command == CMD_STOP) stop_bit = !stop_bit;
         if (res.command == CMD_BUZ) buzzer_bit = !buzzer_bit;
      end
      res.stop_state   = stop_bit;
      res.buzzer_level = buzzer_bit;
      res.overflow     = over_length;
      start_idle();
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BYTE_W-1:0] byte_except_bang();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom_range(0, 255)); while (b == CH_BANG);
      return b;
   endfunction

   // style: mostly ascii digits, some arbitrary bytes, some low bytes for negative digits
   function automatic logic [BYTE_W-1:0] value_char(input int style);
      if (style < 7) return DIGIT_BASE + BYTE_W'($urandom_range(0, 9));
      if (style < 9) return byte_except_bang();
      return BYTE_W'($urandom_range(0, 32));
   endfunction

   function automatic void build_frame();
      int    shape, style, r, len, target;
      string kw;
      frame_q.delete();
      frame_q.push_back(CH_BANG);
      shape = $urandom_range(0, 99);
      style = $urandom_range(0, 9);
      if (shape < 5) begin
         // closes inside the name
         repeat ($urandom_range(0, 3)) frame_q.push_back(byte_except_bang());
         frame_q.push_back(CH_BANG);
         return;
      end
      if (shape < 75) begin
         kw = key_names[$urandom_range(0, NUM_KEYS - 1)];
         for (int k = 0; k < kw.len(); k++) frame_q.push_back(kw[k]);
         if ($urandom_range(0, 9) == 0) frame_q[$urandom_range(1, kw.len())] = byte_except_bang();
      end else begin
         repeat ($urandom_range(1, 5)) frame_q.push_back(byte_except_bang());
      end
      if ($urandom_range(0, 9) != 0) begin
         if ($urandom_range(0, 6) == 0) begin
            // stale value, restarted by the later equals
            frame_q.push_back(CH_EQ);
            repeat ($urandom_range(1, 3)) frame_q.push_back(value_char(0));
         end
         frame_q.push_back(CH_EQ);
         if ($urandom_range(0, 9) < 4) frame_q.push_back(CH_MINUS);
         r = $urandom_range(0, 99);
         len = (r < 70) ? $urandom_range(0, 4) : (r < 90) ? $urandom_range(5, 9)
                                                          : $urandom_range(10, 14);
         repeat (len) frame_q.push_back(value_char(style));
         if ($urandom_range(0, 9) < 6) begin
            frame_q.push_back(CH_POINT);
            repeat ($urandom_range(0, 7)) frame_q.push_back(value_char(style));
            if ($urandom_range(0, 9) == 0) begin
               frame_q.push_back($urandom_range(0, 1) ? CH_POINT : CH_MINUS);
               frame_q.push_back(value_char(0));
            end
         end
      end else begin
         repeat ($urandom_range(0, 4)) frame_q.push_back(byte_except_bang());
      end
      r = $urandom_range(0, 99);
      if (r < 10) target = $urandom_range(28, 40);
      else if (r < 12) target = $urandom_range(60, 75);
      else target = 0;
      while (frame_q.size() < target - 1) frame_q.push_back(value_char(style));
      frame_q.push_back(CH_BANG);
   endfunction

   task automatic send_request(input logic [BYTE_W-1:0] rx, input bit typed,
                               input frame_result_type given);
      frame_result_type predicted;
      int               gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (in_frame || rx == CH_BANG) request_count++;
      if (parse_uart_byte(rx, predicted)) begin
         if (typed) predicted = given;
         results_due.push_back(predicted);
         frame_count++;
         if (predicted.overflow) long_frames++;
         if (predicted.command == CMD_STOP || predicted.command == CMD_BUZ) toggle_count++;
         if (predicted.value == VAL_MAX || predicted.value == VAL_MIN) saturated_count++;
      end
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
   endtask

   // response side: check, then pick the next stall
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count % 256 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            $error("unexpected response: command %0d, value %0d", rsp_command, rsp_value);
            error_count++;
         end else begin
            oldest = results_due.pop_front();
            if (rsp_command !== oldest.command) begin
               $error("command: expected %0d, got %0d", oldest.command, rsp_command);
               error_count++;
            end
            if (rsp_value !== oldest.value) begin
               $error("value: expected %0d, got %0d", $signed(oldest.value), rsp_value);
               error_count++;
            end
            if (rsp_stop_state !== oldest.stop_state) begin
               $error("stop_state: expected %0b, got %0b", oldest.stop_state, rsp_stop_state);
               error_count++;
            end
            if (rsp_buzzer_level !== oldest.buzzer_level) begin
               $error("buzzer_level: expected %0b, got %0b", oldest.buzzer_level,
                      rsp_buzzer_level);
               error_count++;
            end
            if (rsp_overflow !== oldest.overflow) begin
               $error("overflow: expected %0b, got %0b", oldest.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("uart_command_frame_parser_tb: errors");
      $finish;
   end

   initial begin
      directed_rows = '{
         '{8'h00,   1'b0, '0},
         '{CH_BANG, 1'b0, '0},
         '{CH_BANG, 1'b1, '{CMD_NONE, '0, 1'b0, 1'b0, 1'b0}},
         '{CH_BANG, 1'b0, '0},
         '{"S",     1'b0, '0},
         '{"T",     1'b0, '0},
         '{"O",     1'b0, '0},
         '{"P",     1'b0, '0},
         '{CH_BANG, 1'b1, '{CMD_STOP, '0, 1'b1, 1'b0, 1'b0}},
         '{CH_BANG, 1'b0, '0},
         '{"B",     1'b0, '0},
         '{"u",     1'b0, '0},
         '{"z",     1'b0, '0},
         '{CH_EQ,   1'b0, '0},
         '{CH_MINUS, 1'b0, '0},
         '{CH_POINT, 1'b0, '0},
         '{CH_MINUS, 1'b0, '0},
         '{CH_POINT, 1'b0, '0},
         '{8'hFF,   1'b0, '0},
         '{"2",     1'b0, '0},
         '{"3",     1'b0, '0},
         '{"4",     1'b0, '0},
         '{"5",     1'b0, '0},
         '{CH_BANG, 1'b0, '0}
      };
      start_idle();
      stop_bit   = 1'b0;
      buzzer_bit = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].rx_byte, directed_rows[i].typed,
                      directed_rows[i].result);
      end
      drain_responses();

      while (request_count < REQUEST_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) send_request(byte_except_bang(), 1'b0, '0);
         end
         build_frame();
         foreach (frame_q[k]) send_request(frame_q[k], 1'b0, '0);
         if ($urandom_range(0, 19) == 0) drain_responses();
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("summary: %0d requests in %0d frames, %0d over length, %0d saturated values",
               request_count, frame_count, long_frames, saturated_count);
      $display("summary: %0d stop or buzzer toggles, %0d mismatches", toggle_count,
               error_count);
      if (error_count == 0) begin
         $display("uart_command_frame_parser_tb: clean");
      end else begin
         $display("uart_command_frame_parser_tb: errors");
      end
      $finish;
   end

endmodule
